// ===== src/accel_cruise_motion_profile_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the accelerate-then-cruise profile block
// Shared concurrent assertion forms, clocked on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef ACCEL_CRUISE_MOTION_PROFILE_DEFINES_SVH
`define ACCEL_CRUISE_MOTION_PROFILE_DEFINES_SVH

// same-cycle implication
`define ACMP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ACMP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/acmp_pkg.sv =====
// ----------------------------------------------------------------------------
// acmp_pkg
// Types, constants and helpers shared by the motion profile block.
// ----------------------------------------------------------------------------
package acmp_pkg;

    localparam int VALUE_W  = 32;
    localparam int FRAC_W   = 16;
    localparam int ROOT_W   = VALUE_W + 1;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int PROD_W   = 2 * VALUE_W;
    localparam int ADDR_W   = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_START = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_TOP   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ACC   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_PATH  = 2'd3;

    localparam logic OP_DIST = 1'b0;
    localparam logic OP_TIME = 1'b1;

    localparam logic [1:0] K_DACC = 2'd0;
    localparam logic [1:0] K_DCRU = 2'd1;
    localparam logic [1:0] K_ROOT = 2'd2;
    localparam logic [1:0] K_DIV  = 2'd3;

    typedef logic [VALUE_W-1:0] val_t;

    typedef struct packed {
        logic opcode;
        val_t query_value;
    } query_t;

    typedef struct packed {
        val_t answer;
        val_t total_time;
        logic beyond_end;
    } result_t;

    typedef struct packed {
        logic       internal;
        logic       op;
        logic [1:0] kind;
        logic       div_top;
        val_t       q;
    } req_t;

    typedef struct packed {
        logic       internal;
        logic [1:0] kind;
        logic       beyond;
        logic       div_top;
        val_t       ans;
        val_t       num;
    } side_t;

    typedef struct packed {
        val_t              t_acc;
        val_t              d_acc;
        val_t              total;
        logic [VALUE_W:0]  t_end;
        logic [VALUE_W:0]  d_end;
        logic [PROD_W-1:0] ss;
    } prof_t;

    function automatic val_t sat_val(input logic [RAD_W-1:0] x);
        val_t r;
        if (x[RAD_W-1:VALUE_W] != '0)
            r = '1;
        else
            r = x[VALUE_W-1:0];
        return r;
    endfunction

endpackage

// ===== src/accel_cruise_motion_profile.sv =====
// ----------------------------------------------------------------------------
// accel_cruise_motion_profile
// Accelerate-then-cruise motion profile, distance/time query pipeline.
//
// Registers on the APB port: start_speed 0x0, top_speed 0x4,
// acceleration 0x8, path_length 0xC, all unsigned Q16.16. pready is always
// high. Queries enter on req (opcode 0: distance at time, 1: time at
// distance) and results leave on rsp with the total travel time and a
// beyond-end flag; both channels transfer when valid is high and stall low.
// Throughput is one query per cycle while neither channel stalls. A query
// passes five front stages, one stage per root bit, one per quotient bit
// and one output register.
// After reset and after every register write the sequencer derives the
// profile through the same pipeline in two passes; req_stall
// stays high until that finishes. When rsp is stalled with a result held the
// whole pipeline freezes and req_stall rises; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module accel_cruise_motion_profile
    import acmp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  val_t              pwdata,
    output val_t              prdata,
    output logic              pready,
    input  logic              req_valid,
    output logic              req_stall,
    input  query_t            req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output result_t           rsp
);

    val_t              start_reg, top_reg, acc_reg, path_reg;
    logic              cfg_wr, en, eng_ready, inj_valid;
    req_t              inj_req, fr_req;
    prof_t             prof;
    logic              fr_in_valid, fr_valid, sq_valid, dv_valid, res_valid;
    side_t             fr_side, sq_side, dv_side;
    logic [RAD_W-1:0]  fr_rad;
    logic [ROOT_W-1:0] sq_root;
    logic [VALUE_W:0]  div_num, t_sum;
    val_t              quot;
    logic              rsp_valid_reg;
    result_t           rsp_reg, rsp_next;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            top_reg   <= val_t'(1) << FRAC_BITS;
            acc_reg   <= val_t'(1) << FRAC_BITS;
            path_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[REG_IDX_W+1:2])
                REG_START: start_reg <= pwdata;
                REG_TOP:   top_reg   <= pwdata;
                REG_ACC:   acc_reg   <= pwdata;
                REG_PATH:  path_reg  <= pwdata;
                default:   start_reg <= start_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[REG_IDX_W+1:2])
            REG_START: prdata = start_reg;
            REG_TOP:   prdata = top_reg;
            REG_ACC:   prdata = acc_reg;
            REG_PATH:  prdata = path_reg;
            default:   prdata = '0;
        endcase
    end

    assign en        = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !(eng_ready && en);

    acmp_engine #(.FRAC_BITS(FRAC_BITS)) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .cfg_wr       (cfg_wr),
        .start_speed  (start_reg),
        .top_speed    (top_reg),
        .acceleration (acc_reg),
        .path_length  (path_reg),
        .res_valid    (res_valid),
        .res_val      (quot),
        .ready        (eng_ready),
        .inj_valid    (inj_valid),
        .inj_req      (inj_req),
        .prof         (prof)
    );

    always_comb
    begin
        fr_req          = '0;
        fr_req.internal = 1'b0;
        fr_req.op       = req.opcode;
        fr_req.kind     = K_DACC;
        fr_req.q        = req.query_value;
        if (inj_valid)
            fr_req = inj_req;
    end

    assign fr_in_valid = inj_valid || (req_valid && !req_stall);

    acmp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (fr_in_valid),
        .in_req       (fr_req),
        .start_speed  (start_reg),
        .top_speed    (top_reg),
        .acceleration (acc_reg),
        .prof         (prof),
        .out_valid    (fr_valid),
        .out_side     (fr_side),
        .out_rad      (fr_rad)
    );

    acmp_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_side   (fr_side),
        .in_rad    (fr_rad),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_root  (sq_root)
    );

    always_comb
    begin
        if (sq_side.kind == K_ROOT)
            div_num = (sq_root > {1'b0, start_reg}) ? sq_root - {1'b0, start_reg} : '0;
        else
            div_num = {1'b0, sq_side.num};
    end

    acmp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (sq_valid),
        .in_side     (sq_side),
        .in_num      (div_num),
        .divisor_acc (acc_reg),
        .divisor_top (top_reg),
        .out_valid   (dv_valid),
        .out_side    (dv_side),
        .out_quot    (quot)
    );

    assign res_valid = dv_valid && dv_side.internal && en;
    assign t_sum     = {1'b0, prof.t_acc} + {1'b0, quot};

    always_comb
    begin
        rsp_next            = '0;
        rsp_next.total_time = prof.total;
        rsp_next.beyond_end = dv_side.beyond;
        if (!dv_side.beyond)
        begin
            unique case (dv_side.kind)
                K_DACC:  rsp_next.answer = dv_side.ans;
                K_DCRU:  rsp_next.answer = dv_side.ans;
                K_ROOT:  rsp_next.answer = quot;
                K_DIV:   rsp_next.answer = t_sum[VALUE_W] ? '1 : t_sum[VALUE_W-1:0];
                default: rsp_next.answer = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (en)
            rsp_valid_reg <= dv_valid && !dv_side.internal;
    end

    always_ff @(posedge clk)
    begin
        if (en && dv_valid && !dv_side.internal)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== src/acmp_front.sv =====
// ----------------------------------------------------------------------------
// acmp_front
// Five-stage front: phase decode, products, distance answer and radicand.
// ----------------------------------------------------------------------------
module acmp_front
    import acmp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  req_t             in_req,
    input  val_t             start_speed,
    input  val_t             top_speed,
    input  val_t             acceleration,
    input  prof_t            prof,
    output logic             out_valid,
    output side_t            out_side,
    output logic [RAD_W-1:0] out_rad
);

    logic [4:0]        vld_reg;
    side_t             side1_next, side5_next;
    side_t             side1_reg, side2_reg, side3_reg, side4_reg, side5_reg;
    val_t              q1_reg, q2_reg, q3_reg;
    logic [PROD_W-1:0] p_sq2_reg, p_aq2_reg, p_td2_reg, p2_4_reg;
    val_t              fs3_reg, faq3_reg, ft3_reg, fs4_reg, dc4_reg;
    logic [RAD_W-1:0]  rad3_reg, rad4_reg, rad5_reg;
    val_t              f2, da;

    always_comb
    begin
        side1_next          = '0;
        side1_next.internal = in_req.internal;
        side1_next.kind     = in_req.kind;
        side1_next.div_top  = in_req.div_top;
        side1_next.num      = in_req.q;
        if (!in_req.internal)
        begin
            side1_next.div_top = 1'b0;
            if (in_req.op == OP_DIST)
            begin
                side1_next.num = in_req.q - prof.t_acc;
                if (in_req.q < prof.t_acc)
                begin
                    side1_next.kind = K_DACC;
                end
                else
                begin
                    side1_next.kind   = K_DCRU;
                    side1_next.beyond = !({1'b0, in_req.q} < prof.t_end);
                end
            end
            else
            begin
                side1_next.num = in_req.q - prof.d_acc;
                if (in_req.q < prof.d_acc)
                begin
                    side1_next.kind = K_ROOT;
                end
                else
                begin
                    side1_next.kind    = K_DIV;
                    side1_next.div_top = 1'b1;
                    side1_next.beyond  = !({1'b0, in_req.q} < prof.d_end);
                end
            end
        end
    end

    assign f2 = sat_val(RAD_W'(p2_4_reg) >> FRAC_BITS);
    assign da = sat_val(RAD_W'(fs4_reg) + RAD_W'(f2 >> 1));

    always_comb
    begin
        side5_next     = side4_reg;
        side5_next.ans = (side4_reg.kind == K_DACC) ? da : dc4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= side1_next;
            q1_reg    <= in_req.q;

            side2_reg <= side1_reg;
            q2_reg    <= q1_reg;
            p_sq2_reg <= PROD_W'(start_speed) * PROD_W'(q1_reg);
            p_aq2_reg <= PROD_W'(acceleration) * PROD_W'(q1_reg);
            p_td2_reg <= PROD_W'(top_speed) * PROD_W'(side1_reg.num);

            side3_reg <= side2_reg;
            q3_reg    <= q2_reg;
            fs3_reg   <= sat_val(RAD_W'(p_sq2_reg) >> FRAC_BITS);
            faq3_reg  <= sat_val(RAD_W'(p_aq2_reg) >> FRAC_BITS);
            ft3_reg   <= sat_val(RAD_W'(p_td2_reg) >> FRAC_BITS);
            rad3_reg  <= RAD_W'(prof.ss) + (RAD_W'(p_aq2_reg) << 1);

            side4_reg <= side3_reg;
            p2_4_reg  <= PROD_W'(faq3_reg) * PROD_W'(q3_reg);
            dc4_reg   <= sat_val(RAD_W'(prof.d_acc) + RAD_W'(ft3_reg));
            fs4_reg   <= fs3_reg;
            rad4_reg  <= rad3_reg;

            side5_reg <= side5_next;
            rad5_reg  <= rad4_reg;
        end
    end

    assign out_valid = vld_reg[4];
    assign out_side  = side5_reg;
    assign out_rad   = rad5_reg;

endmodule

// ===== src/acmp_sqrt.sv =====
// ----------------------------------------------------------------------------
// acmp_sqrt
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module acmp_sqrt
    import acmp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  side_t             in_side,
    input  logic [RAD_W-1:0]  in_rad,
    output logic              out_valid,
    output side_t             out_side,
    output logic [ROOT_W-1:0] out_root
);

    logic              vld_reg  [ROOT_W];
    side_t             side_reg [ROOT_W];
    logic [RAD_W-1:0]  work_reg [ROOT_W];
    logic [ROOT_W+1:0] rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    for (genvar gi = 0; gi < ROOT_W; gi++)
    begin : g_stage
        logic              prev_v;
        side_t             prev_side;
        logic [RAD_W-1:0]  prev_work;
        logic [ROOT_W+1:0] prev_rem;
        logic [ROOT_W-1:0] prev_root;
        logic [ROOT_W+3:0] tr_rem, trial, diff;
        logic              take;

        if (gi == 0)
        begin : g_first
            assign prev_v    = in_valid;
            assign prev_side = in_side;
            assign prev_work = in_rad;
            assign prev_rem  = '0;
            assign prev_root = '0;
        end
        else
        begin : g_next
            assign prev_v    = vld_reg[gi-1];
            assign prev_side = side_reg[gi-1];
            assign prev_work = work_reg[gi-1];
            assign prev_rem  = rem_reg[gi-1];
            assign prev_root = root_reg[gi-1];
        end

        assign tr_rem = {prev_rem, prev_work[RAD_W-1 -: 2]};
        assign trial  = {2'b00, prev_root, 2'b01};
        assign take   = (tr_rem >= trial);
        assign diff   = tr_rem - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[gi] <= 1'b0;
            else if (en)
                vld_reg[gi] <= prev_v;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[gi] <= prev_side;
                work_reg[gi] <= prev_work << 2;
                rem_reg[gi]  <= take ? diff[ROOT_W+1:0] : tr_rem[ROOT_W+1:0];
                root_reg[gi] <= {prev_root[ROOT_W-2:0], take};
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];

endmodule

// ===== src/acmp_div.sv =====
// ----------------------------------------------------------------------------
// acmp_div
// Pipelined restoring fixed-point divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module acmp_div
    import acmp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  side_t            in_side,
    input  logic [VALUE_W:0] in_num,
    input  val_t             divisor_acc,
    input  val_t             divisor_top,
    output logic             out_valid,
    output side_t            out_side,
    output val_t             out_quot
);

    localparam int NUM_W = VALUE_W + 1 + FRAC_BITS;

    logic             vld_reg  [NUM_W];
    side_t            side_reg [NUM_W];
    logic [NUM_W-1:0] work_reg [NUM_W];
    val_t             rem_reg  [NUM_W];

    for (genvar gi = 0; gi < NUM_W; gi++)
    begin : g_stage
        logic             prev_v;
        side_t            prev_side;
        logic [NUM_W-1:0] prev_work;
        val_t             prev_rem;
        logic [VALUE_W:0] t, d, diff;
        logic             take;

        if (gi == 0)
        begin : g_first
            assign prev_v    = in_valid;
            assign prev_side = in_side;
            assign prev_work = {in_num, {FRAC_BITS{1'b0}}};
            assign prev_rem  = '0;
        end
        else
        begin : g_next
            assign prev_v    = vld_reg[gi-1];
            assign prev_side = side_reg[gi-1];
            assign prev_work = work_reg[gi-1];
            assign prev_rem  = rem_reg[gi-1];
        end

        assign t    = {prev_rem, prev_work[NUM_W-1]};
        assign d    = {1'b0, (prev_side.div_top ? divisor_top : divisor_acc)};
        assign take = (t >= d);
        assign diff = t - d;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[gi] <= 1'b0;
            else if (en)
                vld_reg[gi] <= prev_v;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[gi] <= prev_side;
                work_reg[gi] <= {prev_work[NUM_W-2:0], take};
                rem_reg[gi]  <= take ? diff[VALUE_W-1:0] : t[VALUE_W-1:0];
            end
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];
    assign out_quot  = (work_reg[NUM_W-1][NUM_W-1:VALUE_W] != '0) ? '1
                                                               : work_reg[NUM_W-1][VALUE_W-1:0];

endmodule

// ===== src/acmp_engine.sv =====
// ----------------------------------------------------------------------------
// acmp_engine
// Profile sequencer: derives phase times and distances after reset and after
// each register write, using the shared divide and root pipeline.
// ----------------------------------------------------------------------------
`include "accel_cruise_motion_profile_defines.svh"

module acmp_engine
    import acmp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_W
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  cfg_wr,
    input  val_t  start_speed,
    input  val_t  top_speed,
    input  val_t  acceleration,
    input  val_t  path_length,
    input  logic  res_valid,
    input  val_t  res_val,
    output logic  ready,
    output logic  inj_valid,
    output req_t  inj_req,
    output prof_t prof
);

    localparam logic [3:0] S_START   = 4'd0;
    localparam logic [3:0] S_ISS_TF  = 4'd1;
    localparam logic [3:0] S_WAIT_TF = 4'd2;
    localparam logic [3:0] S_DFULL   = 4'd3;
    localparam logic [3:0] S_CMP     = 4'd4;
    localparam logic [3:0] S_ISS2    = 4'd5;
    localparam logic [3:0] S_WAIT2   = 4'd6;
    localparam logic [3:0] S_TOTAL   = 4'd7;
    localparam logic [3:0] S_READY   = 4'd8;

    logic [3:0]         state_reg, state_next;
    logic               restart_reg, restart_next;
    logic               short_reg;
    val_t               dv_reg, t_full_reg;
    logic [PROD_W:0]    prod_reg;
    val_t               t_acc_reg, d_acc_reg, t_cru_reg, d_cru_reg, total_reg;
    logic [VALUE_W:0]   t_end_reg, d_end_reg, t_sum;
    logic [PROD_W-1:0]  ss_reg;
    val_t               d_full;

    assign d_full = sat_val(RAD_W'(prod_reg) >> (FRAC_BITS + 1));
    assign t_sum  = {1'b0, t_acc_reg} + {1'b0, t_cru_reg};

    always_comb
    begin
        state_next   = state_reg;
        restart_next = 1'b0;
        unique case (state_reg)
            S_START:
                state_next = cfg_wr ? S_START : S_ISS_TF;
            S_ISS_TF:
            begin
                if (en)
                begin
                    state_next   = S_WAIT_TF;
                    restart_next = cfg_wr;
                end
                else if (cfg_wr)
                    state_next = S_START;
            end
            S_WAIT_TF:
            begin
                restart_next = restart_reg || cfg_wr;
                if (res_valid)
                begin
                    state_next   = (restart_reg || cfg_wr) ? S_START : S_DFULL;
                    restart_next = 1'b0;
                end
            end
            S_DFULL:
                state_next = cfg_wr ? S_START : S_CMP;
            S_CMP:
                state_next = cfg_wr ? S_START : S_ISS2;
            S_ISS2:
            begin
                if (en)
                begin
                    state_next   = S_WAIT2;
                    restart_next = cfg_wr;
                end
                else if (cfg_wr)
                    state_next = S_START;
            end
            S_WAIT2:
            begin
                restart_next = restart_reg || cfg_wr;
                if (res_valid)
                begin
                    state_next   = (restart_reg || cfg_wr) ? S_START : S_TOTAL;
                    restart_next = 1'b0;
                end
            end
            S_TOTAL:
                state_next = cfg_wr ? S_START : S_READY;
            S_READY:
                state_next = cfg_wr ? S_START : S_READY;
            default:
                state_next = S_START;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_START;
            restart_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            restart_reg <= restart_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_START:
            begin
                dv_reg <= (top_speed > start_speed) ? top_speed - start_speed : '0;
                ss_reg <= PROD_W'(start_speed) * PROD_W'(start_speed);
            end
            S_WAIT_TF:
            begin
                if (res_valid)
                    t_full_reg <= res_val;
            end
            S_DFULL:
                prod_reg <= (PROD_W+1)'({1'b0, start_speed} + {1'b0, top_speed})
                            * (PROD_W+1)'(t_full_reg);
            S_CMP:
            begin
                short_reg <= (path_length <= d_full);
                if (path_length <= d_full)
                begin
                    d_acc_reg <= path_length;
                    d_cru_reg <= '0;
                    t_cru_reg <= '0;
                end
                else
                begin
                    t_acc_reg <= t_full_reg;
                    d_acc_reg <= d_full;
                    d_cru_reg <= path_length - d_full;
                end
            end
            S_WAIT2:
            begin
                if (res_valid)
                begin
                    if (short_reg)
                        t_acc_reg <= res_val;
                    else
                        t_cru_reg <= res_val;
                end
            end
            S_TOTAL:
            begin
                t_end_reg <= t_sum;
                d_end_reg <= {1'b0, d_acc_reg} + {1'b0, d_cru_reg};
                total_reg <= t_sum[VALUE_W] ? '1 : t_sum[VALUE_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        inj_req          = '0;
        inj_req.internal = 1'b1;
        inj_req.op       = OP_TIME;
        if (state_reg == S_ISS_TF)
        begin
            inj_req.kind    = K_DIV;
            inj_req.div_top = 1'b0;
            inj_req.q       = dv_reg;
        end
        else if (short_reg)
        begin
            inj_req.kind    = K_ROOT;
            inj_req.div_top = 1'b0;
            inj_req.q       = path_length;
        end
        else
        begin
            inj_req.kind    = K_DIV;
            inj_req.div_top = 1'b1;
            inj_req.q       = d_cru_reg;
        end
    end

    assign inj_valid  = (state_reg == S_ISS_TF) || (state_reg == S_ISS2);
    assign ready      = (state_reg == S_READY);
    assign prof.t_acc = t_acc_reg;
    assign prof.d_acc = d_acc_reg;
    assign prof.total = total_reg;
    assign prof.t_end = t_end_reg;
    assign prof.d_end = d_end_reg;
    assign prof.ss    = ss_reg;

    `ACMP_ASSERT_IMP(a_res_in_wait, res_valid, (state_reg == S_WAIT_TF) || (state_reg == S_WAIT2), "profile result outside a wait state")
    `ACMP_ASSERT_NXT(a_wait_exits, res_valid, (state_reg != S_WAIT_TF) && (state_reg != S_WAIT2), "wait state held after its result")
    `ACMP_ASSERT_IMP(a_path_cover, state_reg == S_READY, d_end_reg == {1'b0, path_length}, "phase distances do not cover the path")

endmodule

// ===== bench/tb_accel_cruise_motion_profile.sv =====
// ----------------------------------------------------------------------------
// Testbench for accel_cruise_motion_profile
// Loads profile settings over APB, streams distance and time queries through
// a randomly idling driver, and checks every result field against a local
// fixed-point predictor of the accelerate-then-cruise profile.
// ----------------------------------------------------------------------------
module tb_accel_cruise_motion_profile;
    import acmp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [127:0] wide_t;
    localparam wide_t VMAX = 128'hFFFF_FFFF;
    localparam val_t ONE = 32'h0001_0000;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int HOLD_CYCLES = 400;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    val_t              pwdata;
    val_t              prdata;
    logic              pready;
    logic              req_valid;
    logic              req_stall;
    query_t            req;
    logic              rsp_valid;
    logic              rsp_stall;
    result_t           rsp;

    accel_cruise_motion_profile dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    // profile settings as last written
    val_t start_spd, top_spd, accel, path_len;

    query_t  pending_queries[$];
    result_t expected_results[$];
    int      errors;
    int      queries_sent;
    int      results_checked;
    int      settings_used;
    bit      send_idle;
    bit      recv_idle;
    int      hold_asked;
    int      hold_done;
    int      quiet_cycles;

    function automatic val_t sat_q(wide_t x);
        return (x > VMAX) ? '1 : x[31:0];
    endfunction

    function automatic val_t qmul(val_t a, val_t b);
        wide_t p;
        p = wide_t'(a) * wide_t'(b);
        return sat_q(p >> FRAC_W);
    endfunction

    function automatic val_t qdiv(wide_t a, val_t b);
        if (b == '0)
            return '1;
        return sat_q((a << FRAC_W) / wide_t'(b));
    endfunction

    function automatic wide_t isqrt(wide_t x);
        wide_t r;
        wide_t cand;
        r = '0;
        for (int i = 50; i >= 0; i--)
        begin
            cand = r | (wide_t'(1) << i);
            if (cand * cand <= x)
                r = cand;
        end
        return r;
    endfunction

    // time needed to cover d from start speed under constant acceleration
    function automatic val_t ramp_time(val_t d);
        wide_t inner;
        wide_t s;
        inner = wide_t'(start_spd) * wide_t'(start_spd)
              + 2 * wide_t'(accel) * wide_t'(d);
        s = isqrt(inner);
        return qdiv((s > wide_t'(start_spd)) ? s - wide_t'(start_spd) : '0, accel);
    endfunction

    function automatic void profile(output val_t t_acc, output val_t d_acc,
                                    output val_t t_cru, output val_t d_cru);
        val_t dv;
        val_t t_full;
        val_t d_full;
        dv = (top_spd > start_spd) ? top_spd - start_spd : '0;
        t_full = qdiv(dv, accel);
        d_full = sat_q(((wide_t'(start_spd) + top_spd) * wide_t'(t_full)) >> (FRAC_W + 1));
        if (path_len <= d_full)
        begin
            t_acc = ramp_time(path_len);
            d_acc = path_len;
            t_cru = '0;
            d_cru = '0;
        end
        else
        begin
            t_acc = t_full;
            d_acc = d_full;
            d_cru = path_len - d_full;
            t_cru = qdiv(d_cru, top_spd);
        end
    endfunction

    function automatic result_t predict_motion(query_t qr);
        val_t t_acc, d_acc, t_cru, d_cru;
        val_t q;
        result_t r;
        profile(t_acc, d_acc, t_cru, d_cru);
        q = qr.query_value;
        r.answer = '0;
        r.beyond_end = 1'b0;
        r.total_time = sat_q(wide_t'(t_acc) + t_cru);
        if (qr.opcode == OP_DIST)
        begin
            if (q < t_acc)
                r.answer = sat_q(wide_t'(qmul(start_spd, q))
                               + (qmul(qmul(accel, q), q) >> 1));
            else if (wide_t'(q) < wide_t'(t_acc) + t_cru)
                r.answer = sat_q(wide_t'(d_acc) + qmul(top_spd, q - t_acc));
            else
                r.beyond_end = 1'b1;
        end
        else
        begin
            if (q < d_acc)
                r.answer = ramp_time(q);
            else if (wide_t'(q) < wide_t'(d_acc) + d_cru)
                r.answer = sat_q(wide_t'(t_acc) + qdiv(q - d_acc, top_spd));
            else
                r.beyond_end = 1'b1;
        end
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // driver
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        query_t nq;
        bit     free;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            gap_left = 0;
        end
        else
        begin
            free = !req_valid;
            if (req_valid && !req_stall)
            begin
                expected_results.push_back(predict_motion(req));
                queries_sent++;
                free = 1'b1;
            end
            if (free)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pending_queries.size() > 0)
                begin
                    nq = pending_queries.pop_front();
                    req <= nq;
                    req_valid <= 1'b1;
                    gap_left = send_idle ? $urandom_range(0, 19) : 0;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: transfer with nothing expected: answer %h total %h beyond %b",
                             $time, rsp.answer, rsp.total_time, rsp.beyond_end);
                    errors++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (rsp.answer !== exp_r.answer)
                    begin
                        $display("%0t: answer expected %h actual %h",
                                 $time, exp_r.answer, rsp.answer);
                        errors++;
                    end
                    if (rsp.total_time !== exp_r.total_time)
                    begin
                        $display("%0t: total_time expected %h actual %h",
                                 $time, exp_r.total_time, rsp.total_time);
                        errors++;
                    end
                    if (rsp.beyond_end !== exp_r.beyond_end)
                    begin
                        $display("%0t: beyond_end expected %b actual %b",
                                 $time, exp_r.beyond_end, rsp.beyond_end);
                        errors++;
                    end
                end
                stall_left = recv_idle ? $urandom_range(0, 19) : 0;
            end
            if (hold_done < hold_asked)
            begin
                hold_done++;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
            || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: %0d queries pending, %0d results outstanding",
                     pending_queries.size(), expected_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic apb_write(logic [REG_IDX_W-1:0] idx, val_t value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_START: start_spd = value;
            REG_TOP:   top_spd = value;
            REG_ACC:   accel = value;
            default:   path_len = value;
        endcase
    endtask

    task automatic load_profile(val_t s, val_t t, val_t a, val_t p);
        apb_write(REG_START, s);
        apb_write(REG_TOP, t);
        apb_write(REG_ACC, a);
        apb_write(REG_PATH, p);
        settings_used++;
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending_queries.size() > 0 || req_valid || expected_results.size() > 0)
            @(negedge clk);
    endtask

    task automatic push_query(logic op, val_t v);
        query_t qr;
        qr.opcode = op;
        qr.query_value = v;
        pending_queries.push_back(qr);
    endtask

    // mostly in-range queries, some near the phase bounds, some anywhere
    task automatic random_queries(int n);
        val_t t_acc, d_acc, t_cru, d_cru;
        val_t t_end, d_end, b, v;
        logic op;
        profile(t_acc, d_acc, t_cru, d_cru);
        t_end = sat_q(wide_t'(t_acc) + t_cru);
        d_end = sat_q(wide_t'(d_acc) + d_cru);
        for (int i = 0; i < n; i++)
        begin
            op = $urandom_range(0, 1);
            b = (op == OP_DIST) ? t_end : d_end;
            case ($urandom_range(0, 9))
                0: v = $urandom;
                1: v = (op == OP_DIST) ? t_acc + $urandom_range(0, 2) - 1
                                       : d_acc + $urandom_range(0, 2) - 1;
                2: v = b + $urandom_range(0, 2) - 1;
                default: v = $urandom_range(0, b);
            endcase
            push_query(op, v);
        end
    endtask

    function automatic val_t rand_value(bit nonzero);
        val_t v;
        v = $urandom >> $urandom_range(0, 31);
        if (nonzero && v == '0)
            v = 1;
        return v;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        queries_sent = 0;
        results_checked = 0;
        settings_used = 1;
        send_idle = 1'b0;
        recv_idle = 1'b0;
        hold_asked = 0;
        hold_done = 0;
        quiet_cycles = 0;
        start_spd = '0;
        top_spd = ONE;
        accel = ONE;
        path_len = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset profile: zero length path, everything past the end
        push_query(OP_DIST, '0);
        push_query(OP_TIME, '0);
        push_query(OP_DIST, '1);
        push_query(OP_TIME, '1);
        random_queries(20);
        drain();

        // accelerate then cruise, with boundary queries
        load_profile(ONE, 10 * ONE, 2 * ONE, 100 * ONE);
        push_query(OP_DIST, 32'h0004_8000 - 1);
        push_query(OP_DIST, 32'h0004_8000);
        push_query(OP_TIME, 32'h0018_C000 - 1);
        push_query(OP_TIME, 32'h0018_C000);
        push_query(OP_DIST, '1);
        push_query(OP_TIME, '1);
        push_query(OP_DIST, 32'h0000_0001);
        push_query(OP_TIME, 32'h0000_0001);
        random_queries(140);
        drain();

        // back pressure: long receiver hold while the sender keeps offering
        hold_asked++;
        random_queries(200);
        drain();

        send_idle = 1'b1;
        recv_idle = 1'b1;

        // short path: never reaches top speed
        load_profile(3 * ONE, 40 * ONE, ONE >> 2, 5 * ONE);
        random_queries(120);
        drain();

        // start above top: no acceleration phase
        load_profile(20 * ONE, 4 * ONE, ONE, 50 * ONE);
        random_queries(100);
        drain();

        // extremes
        load_profile('1, '1, '1, '1);
        push_query(OP_DIST, '1);
        push_query(OP_TIME, '0);
        random_queries(60);
        drain();
        load_profile('0, '1, 32'h1, '1);
        random_queries(80);
        drain();
        load_profile('0, 32'h1, '1, '1);
        random_queries(60);
        drain();

        send_idle = 1'b1;
        recv_idle = 1'b0;
        for (int k = 0; k < 5; k++)
        begin
            load_profile(rand_value(0), rand_value(1), rand_value(1), rand_value(0));
            random_queries(80);
            if (k == 2)
            begin
                send_idle = 1'b0;
                recv_idle = 1'b1;
            end
            drain();
        end

        repeat (120) @(posedge clk);
        $display("ran %0d queries over %0d profile settings, %0d results checked",
                 queries_sent, settings_used, results_checked);
        $display("covered both query kinds, short and long paths, extremes, long hold");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
